/* hw/rtl/arpc_pkg.sv */
// Shared types, sizes and codes of the ARP cache table.
// Used by arpc_cell and arp_cache_table_top; depends on nothing else.
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int AGE_W   = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd120;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_LEARN_IP = 2'd1,
    CMD_LEARN_ARP = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_MISS     = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_UPDATED  = 3'd2,
    OUT_INSERTED = 3'd3,
    OUT_REPLACED = 3'd4,
    OUT_FILTERED = 3'd5,
    OUT_TICK     = 3'd6
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_IP      = 2'd0,
    REG_SUBNET_MASK = 2'd1,
    REG_MAX_AGE     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;
  } arpc_in_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [MAC_W-1:0] mac_found;
    logic [3:0]       slot_index;
    logic [4:0]       expired_count;
  } arpc_out_t;

  // Token that walks down the row of cells, gathering the search results.
  typedef struct packed {
    logic               tick;
    logic [IP_W-1:0]    ip;
    logic [STAMP_W-1:0] stamp_now;
    logic [AGE_W-1:0]   max_age;
    logic               match_hit;
    logic [SLOT_W-1:0]  match_slot;
    logic [MAC_W-1:0]   match_mac;
    logic               free_hit;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  old_slot;
    logic [STAMP_W-1:0] old_age;
    logic [CNT_W-1:0]   expired;
  } arpc_scan_t;

  // Write broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } arpc_wr_t;

endpackage

/* hw/rtl/arpc_cell.sv */
// One slot of the ARP cache: holds an entry and updates the passing scan token.
// Depends on arpc_pkg.
module arpc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [arpc_pkg::SLOT_W-1:0]  idx,
  input  logic                         scan_in_valid,
  input  arpc_pkg::arpc_scan_t         scan_in,
  input  arpc_pkg::arpc_wr_t           wr,
  output logic                         scan_out_valid,
  output arpc_pkg::arpc_scan_t         scan_out
);

  logic                               valid;
  logic                               valid_next;
  logic [arpc_pkg::IP_W-1:0]          ip;
  logic [arpc_pkg::MAC_W-1:0]         mac;
  logic [arpc_pkg::STAMP_W-1:0]       stamp;
  logic [arpc_pkg::STAMP_W-1:0]       age;
  logic [arpc_pkg::STAMP_W-1:0]       limit;
  logic                               wr_hit;
  arpc_pkg::arpc_scan_t               scan_next;

  assign wr_hit = wr.en && (wr.slot == idx);

  always_comb begin
    scan_next  = scan_in;
    valid_next = valid;
    age   = scan_in.stamp_now - stamp;
    limit = {{(arpc_pkg::STAMP_W - arpc_pkg::AGE_W){1'b0}}, scan_in.max_age};
    if (scan_in_valid) begin
      if (scan_in.tick) begin
        if (valid && (age >= limit)) begin
          valid_next        = 1'b0;
          scan_next.expired = scan_in.expired + {{(arpc_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
      end else begin
        if (valid && (ip == scan_in.ip) && !scan_in.match_hit) begin
          scan_next.match_hit  = 1'b1;
          scan_next.match_slot = idx;
          scan_next.match_mac  = mac;
        end
        if (!valid && !scan_in.free_hit) begin
          scan_next.free_hit  = 1'b1;
          scan_next.free_slot = idx;
        end
        // Slot zero seeds the oldest search; later slots win only when strictly older.
        if ((idx == '0) || (age > scan_in.old_age)) begin
          scan_next.old_slot = idx;
          scan_next.old_age  = age;
        end
      end
    end
    if (wr_hit) begin
      valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      scan_out_valid <= 1'b0;
    end else begin
      valid          <= valid_next;
      scan_out_valid <= scan_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (wr_hit) begin
      ip    <= wr.ip;
      mac   <= wr.mac;
      stamp <= wr.stamp;
    end
  end

endmodule

/* hw/rtl/arp_cache_table_top.sv */
// Top level of the ARP cache table: control, configuration and the row of cells.
// Depends on arpc_pkg and arpc_cell.
//
// Usage. A request word (command, IPv4 address, MAC address) is taken at a
// rising edge where start is high and busy is low. Lookups, learns and ticks
// send one scan token down a row of ENTRIES cells, one cell per clock; each
// cell holds one cache entry and folds its match, free and age status into
// the token, and on a tick expires itself and counts. When the token leaves
// the last cell the controller picks the slot, writes the learned entry and
// registers the result word. The result word is held on result and marked by done,
// which is high for a single cycle; the receiver cannot stall it.
// The time from accept to done is set by the walk of the token through the
// cell row. A learn from an IP packet that fails the subnet filter is answered
// in the cycle after the accept, without a token. Busy is high while a token
// is in the row, so one request is in flight at a time and a new request can
// be accepted in the cycle that done is shown.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// edge; indexes beyond the register list are ignored.
// Reset (rst, synchronous) invalidates all entries, clears the time counter
// and returns the registers to own address 0, mask 0, maximum age 120.
module arp_cache_table_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  arpc_pkg::arpc_in_t              request,
  output logic                            done,
  output arpc_pkg::arpc_out_t             result,
  input  logic                            cfg_write,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpc_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                         state;
  state_t                         state_next;

  // Configuration registers and the wrapping time counter.
  logic [arpc_pkg::IP_W-1:0]      own_ip;
  logic [arpc_pkg::IP_W-1:0]      subnet_mask;
  logic [arpc_pkg::AGE_W-1:0]     max_age;
  logic [arpc_pkg::STAMP_W-1:0]   current_time;

  // The request being worked on.
  logic [1:0]                     cur_cmd;
  logic [arpc_pkg::MAC_W-1:0]     cur_mac;

  // Scan chain: element 0 is the head token, element ENTRIES leaves the row.
  logic                           scan_valid [arpc_pkg::ENTRIES+1];
  arpc_pkg::arpc_scan_t           scan       [arpc_pkg::ENTRIES+1];
  logic [arpc_pkg::ENTRIES:0]     scan_valid_vec;

  arpc_pkg::arpc_wr_t             wr;
  arpc_pkg::arpc_out_t            result_next;
  arpc_pkg::arpc_scan_t           tail;
  logic                           tail_valid;
  logic                           accept;
  logic                           filtered;
  logic [arpc_pkg::SLOT_W-1:0]    pick_slot;
  logic [arpc_pkg::SLOT_W+3:0]    slot_wide;
  logic [arpc_pkg::CNT_W+4:0]     count_wide;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign tail       = scan[arpc_pkg::ENTRIES];
  assign tail_valid = scan_valid[arpc_pkg::ENTRIES];

  // A learn from a routed packet must come from the own subnet.
  assign filtered = (request.command == arpc_pkg::CMD_LEARN_IP) &&
                    (((request.ip_address ^ own_ip) & subnet_mask) != '0);

  genvar g;
  generate
    for (g = 0; g < arpc_pkg::ENTRIES; g++) begin : g_cell
      arpc_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .idx            (arpc_pkg::SLOT_W'(g)),
        .scan_in_valid  (scan_valid[g]),
        .scan_in        (scan[g]),
        .wr             (wr),
        .scan_out_valid (scan_valid[g+1]),
        .scan_out       (scan[g+1])
      );
    end
    for (g = 0; g <= arpc_pkg::ENTRIES; g++) begin : g_vec
      assign scan_valid_vec[g] = scan_valid[g];
    end
  endgenerate

  // Decide the outcome when the token leaves the last cell.
  always_comb begin
    pick_slot   = '0;
    wr          = '0;
    result_next = '0;
    if (tail.tick) begin
      result_next.outcome = arpc_pkg::OUT_TICK;
    end else if (cur_cmd == arpc_pkg::CMD_LOOKUP) begin
      if (tail.match_hit) begin
        result_next.outcome   = arpc_pkg::OUT_HIT;
        result_next.mac_found = tail.match_mac;
        pick_slot             = tail.match_slot;
      end else begin
        result_next.outcome = arpc_pkg::OUT_MISS;
      end
    end else begin
      priority if (tail.match_hit) begin
        result_next.outcome = arpc_pkg::OUT_UPDATED;
        pick_slot           = tail.match_slot;
      end else if (tail.free_hit) begin
        result_next.outcome = arpc_pkg::OUT_INSERTED;
        pick_slot           = tail.free_slot;
      end else begin
        result_next.outcome = arpc_pkg::OUT_REPLACED;
        pick_slot           = tail.old_slot;
      end
      result_next.mac_found = cur_mac;
      wr.en    = tail_valid;
      wr.slot  = pick_slot;
      wr.ip    = tail.ip;
      wr.mac   = cur_mac;
      wr.stamp = current_time;
    end
    // Slot and count carry only their low bits on wide tables.
    slot_wide                 = {4'b0, pick_slot};
    count_wide                = {5'b0, tail.expired};
    result_next.slot_index    = slot_wide[3:0];
    result_next.expired_count = count_wide[4:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !filtered) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      scan_valid[0] <= 1'b0;
      own_ip        <= '0;
      subnet_mask   <= '0;
      max_age       <= arpc_pkg::MAX_AGE_RESET;
      current_time  <= '0;
    end else begin
      state         <= state_next;
      done          <= (accept && filtered) || tail_valid;
      scan_valid[0] <= accept && !filtered;
      if (accept && (request.command == arpc_pkg::CMD_TICK)) begin
        current_time <= current_time + 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          arpc_pkg::REG_OWN_IP:      own_ip      <= cfg_data[arpc_pkg::IP_W-1:0];
          arpc_pkg::REG_SUBNET_MASK: subnet_mask <= cfg_data[arpc_pkg::IP_W-1:0];
          arpc_pkg::REG_MAX_AGE:     max_age     <= cfg_data[arpc_pkg::AGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: head token, request copy and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd <= request.command;
      cur_mac <= request.mac_address;
      scan[0] <= '{
        tick:       (request.command == arpc_pkg::CMD_TICK),
        ip:         request.ip_address,
        stamp_now:  (request.command == arpc_pkg::CMD_TICK) ?
                    current_time + 1'b1 : current_time,
        max_age:    max_age,
        match_hit:  1'b0,
        match_slot: '0,
        match_mac:  '0,
        free_hit:   1'b0,
        free_slot:  '0,
        old_slot:   '0,
        old_age:    '0,
        expired:    '0
      };
    end
    if (accept && filtered) begin
      result <= '{outcome: arpc_pkg::OUT_FILTERED, default: '0};
    end else if (tail_valid) begin
      result <= result_next;
    end
  end

  // Exactly one token travels the row while a request is in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ($countones(scan_valid_vec) == 1))
    else $error("scan row does not hold exactly one token while scanning");

  a_no_token_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(scan_valid_vec) == 0))
    else $error("token in the scan row while idle");

  a_expire_only_tick: assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome != arpc_pkg::OUT_TICK)) |-> (result.expired_count == '0))
    else $error("expired count set on a result that is not a tick");

  a_write_learn_only: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (tail_valid && !tail.tick && (cur_cmd != arpc_pkg::CMD_LOOKUP)))
    else $error("entry write outside a learn");

endmodule
